// File: hdl/ibc_pkg.sv
// Shared types and constants for the IMU bias calibrator.
// No dependencies; every other file in hdl/ depends on this package.
package ibc_pkg;

	localparam int unsigned CAPTURE_LEN  = 12;
	localparam int unsigned NUM_AXES     = 6;
	localparam int unsigned RAW_W        = 16;
	localparam int unsigned SUM_W        = 20;
	localparam int unsigned OFF_W        = 20;
	localparam int unsigned OUT_W        = 21;
	localparam int unsigned CNT_W        = 5;
	localparam int unsigned REQ_W        = 2;

	localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CAL    = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

	// Rounded mean: q = floor((|sum|*32 + N) / (2N)), done as a multiply by a
	// truncated reciprocal followed by one correction step.
	localparam int unsigned DIV_D    = 2 * CAPTURE_LEN;
	localparam int unsigned X_W      = 25;
	localparam int unsigned RCP_SH   = 25;
	localparam int unsigned RCP_LO_W = 13;
	localparam int unsigned RCP_HI_W = X_W - RCP_LO_W;
	localparam int unsigned PH_W     = X_W + RCP_HI_W;
	localparam int unsigned PL_W     = X_W + RCP_LO_W;
	localparam int unsigned PROD_W   = X_W + X_W;
	localparam logic [X_W-1:0]      RCP_M  = X_W'((64'd1 << RCP_SH) / DIV_D);
	localparam logic [RCP_HI_W-1:0] RCP_MH = RCP_M[X_W-1:RCP_LO_W];
	localparam logic [RCP_LO_W-1:0] RCP_ML = RCP_M[RCP_LO_W-1:0];

	// What an item does once it reaches the back end of the pipe
	typedef enum logic [1:0] {
		K_NONE,
		K_SAMPLE,
		K_FINAL,
		K_CLEAR
	} ibc_kind_t;

	typedef struct packed {
		logic shift;
		logic acc_en;
		logic sum_clr;
		logic off_wr;
		logic off_clr;
	} ibc_lane_ctl_t;

endpackage

// File: hdl/ibc_ifs.sv
// Valid/ready channel interfaces for the IMU bias calibrator.
// Depends on ibc_pkg for field widths.
interface ibc_in_if;
	logic                                valid;
	logic                                ready;
	logic [ibc_pkg::REQ_W-1:0]           req_type;
	logic signed [ibc_pkg::RAW_W-1:0]    acc_x_raw;
	logic signed [ibc_pkg::RAW_W-1:0]    acc_y_raw;
	logic signed [ibc_pkg::RAW_W-1:0]    acc_z_raw;
	logic signed [ibc_pkg::RAW_W-1:0]    gyro_x_raw;
	logic signed [ibc_pkg::RAW_W-1:0]    gyro_y_raw;
	logic signed [ibc_pkg::RAW_W-1:0]    gyro_z_raw;

	modport source (output valid, req_type, acc_x_raw, acc_y_raw, acc_z_raw,
		gyro_x_raw, gyro_y_raw, gyro_z_raw, input ready);
	modport sink (input valid, req_type, acc_x_raw, acc_y_raw, acc_z_raw,
		gyro_x_raw, gyro_y_raw, gyro_z_raw, output ready);
endinterface

interface ibc_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [ibc_pkg::OUT_W-1:0]    acc_x_out;
	logic signed [ibc_pkg::OUT_W-1:0]    acc_y_out;
	logic signed [ibc_pkg::OUT_W-1:0]    acc_z_out;
	logic signed [ibc_pkg::OUT_W-1:0]    gyro_x_out;
	logic signed [ibc_pkg::OUT_W-1:0]    gyro_y_out;
	logic signed [ibc_pkg::OUT_W-1:0]    gyro_z_out;
	logic                                is_calibrated;

	modport source (output valid, acc_x_out, acc_y_out, acc_z_out,
		gyro_x_out, gyro_y_out, gyro_z_out, is_calibrated, input ready);
	modport sink (input valid, acc_x_out, acc_y_out, acc_z_out,
		gyro_x_out, gyro_y_out, gyro_z_out, is_calibrated, output ready);
endinterface

// File: hdl/ibc_ctrl.sv
// Request decode, capture counter, item-kind pipeline and calibrated flag.
// Depends on ibc_pkg.
module ibc_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic                       adv,
	input  logic [ibc_pkg::REQ_W-1:0]  req,
	output ibc_pkg::ibc_lane_ctl_t     ctl,
	output logic                       res_vld,
	output logic                       cal
);
	import ibc_pkg::*;

	logic             capturing_q;
	logic [CNT_W-1:0] count_q;
	logic             cal_q;
	logic             last_smp;
	ibc_kind_t        kind_in;
	ibc_kind_t        kind_s1, kind_s2, kind_s3, kind_s4, kind_s5;

	assign last_smp = capturing_q && (count_q == CNT_W'(CAPTURE_LEN - 1));

	always_comb begin
		kind_in = K_NONE;
		if (accept) begin
			unique case (req)
				REQ_SAMPLE: begin
					if (!capturing_q) kind_in = K_SAMPLE;
					else if (last_smp) kind_in = K_FINAL;
				end
				REQ_CLEAR: kind_in = K_CLEAR;
				default:   kind_in = K_NONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capturing_q <= 1'b0;
			count_q     <= '0;
		end else if (accept) begin
			unique case (req)
				REQ_SAMPLE: begin
					if (last_smp) begin
						capturing_q <= 1'b0;
						count_q     <= '0;
					end else if (capturing_q) begin
						count_q <= count_q + 1'b1;
					end
				end
				REQ_CAL: begin
					capturing_q <= 1'b1;
					count_q     <= '0;
				end
				REQ_CLEAR: begin
					capturing_q <= 1'b0;
					count_q     <= '0;
				end
				default: ;
			endcase
		end
	end

	// kind pipe mirrors the lane stages s1..s5
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_s1 <= K_NONE;
			kind_s2 <= K_NONE;
			kind_s3 <= K_NONE;
			kind_s4 <= K_NONE;
			kind_s5 <= K_NONE;
		end else if (adv) begin
			kind_s1 <= kind_in;
			kind_s2 <= kind_s1;
			kind_s3 <= kind_s2;
			kind_s4 <= kind_s3;
			kind_s5 <= kind_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= 1'b0;
		end else if (adv) begin
			if (kind_s5 == K_FINAL) cal_q <= 1'b1;
			else if (kind_s5 == K_CLEAR) cal_q <= 1'b0;
		end
	end

	assign ctl.shift   = adv;
	assign ctl.acc_en  = accept && (req == REQ_SAMPLE) && capturing_q;
	assign ctl.sum_clr = accept && ((req == REQ_CAL) || (req == REQ_CLEAR) ||
		((req == REQ_SAMPLE) && last_smp));
	assign ctl.off_wr  = adv && (kind_s5 == K_FINAL);
	assign ctl.off_clr = adv && (kind_s5 == K_CLEAR);
	assign res_vld     = (kind_s5 == K_SAMPLE);
	assign cal         = cal_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CNT_W'(CAPTURE_LEN)) else $error("capture count out of range");
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!capturing_q |-> count_q == '0) else $error("count nonzero while idle");
	a_final_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(kind_in == K_FINAL) |=> (!capturing_q && count_q == '0))
		else $error("capture did not end on its last sample");
	a_clear_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && kind_s5 == K_CLEAR) |=> !cal_q) else $error("flag survived a clear");

endmodule

// File: hdl/ibc_lane.sv
// One axis lane: capture sum, rounded-mean pipeline, offset and correction.
// Depends on ibc_pkg.
module ibc_lane (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ibc_pkg::ibc_lane_ctl_t           ctl,
	input  logic signed [ibc_pkg::RAW_W-1:0] raw,
	output logic signed [ibc_pkg::OUT_W-1:0] corr
);
	import ibc_pkg::*;

	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] sum_nx;
	logic signed [OFF_W-1:0] off_q;

	logic signed [RAW_W-1:0] raw_s1, raw_s2, raw_s3, raw_s4, raw_s5;
	logic signed [SUM_W-1:0] sum_s1;
	logic [SUM_W-1:0]        mag;
	logic [X_W-1:0]          x_s2, x_s3, x_s4;
	logic                    neg_s2, neg_s3, neg_s4, neg_s5;
	logic [PH_W-1:0]         ph_s3;
	logic [PL_W-1:0]         pl_s3;
	logic [PROD_W-1:0]       prod;
	logic [OFF_W-1:0]        qe_s4, q_s5;
	logic [X_W-1:0]          rem;

	assign sum_nx = sum_q + SUM_W'(raw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.sum_clr) begin
			sum_q <= '0;
		end else if (ctl.acc_en) begin
			sum_q <= sum_nx;
		end
	end

	assign mag  = sum_s1[SUM_W-1] ? SUM_W'(-sum_s1) : SUM_W'(sum_s1);
	assign prod = {ph_s3, {RCP_LO_W{1'b0}}} + PROD_W'(pl_s3);
	// estimate is exact or one low
	assign rem  = x_s4 - X_W'(qe_s4) * X_W'(DIV_D);

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			raw_s1 <= raw;
			sum_s1 <= sum_nx;
			raw_s2 <= raw_s1;
			x_s2   <= {mag, 5'b0} + X_W'(CAPTURE_LEN);
			neg_s2 <= sum_s1[SUM_W-1];
			raw_s3 <= raw_s2;
			ph_s3  <= x_s2 * RCP_MH;
			pl_s3  <= x_s2 * RCP_ML;
			x_s3   <= x_s2;
			neg_s3 <= neg_s2;
			raw_s4 <= raw_s3;
			qe_s4  <= prod[RCP_SH +: OFF_W];
			x_s4   <= x_s3;
			neg_s4 <= neg_s3;
			raw_s5 <= raw_s4;
			q_s5   <= qe_s4 + OFF_W'(rem >= X_W'(DIV_D));
			neg_s5 <= neg_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
		end else if (ctl.off_clr) begin
			off_q <= '0;
		end else if (ctl.off_wr) begin
			off_q <= neg_s5 ? -$signed(q_s5) : $signed(q_s5);
		end
	end

	assign corr = {raw_s5[RAW_W-1], raw_s5, 4'b0} - {off_q[OFF_W-1], off_q};

endmodule

// File: hdl/ibc_merge.sv
// Output register: gathers the six lane results and the calibrated flag.
// Depends on ibc_pkg and ibc_out_if.
module ibc_merge (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             res_vld,
	input  logic                             cal,
	input  logic signed [ibc_pkg::OUT_W-1:0] corr [ibc_pkg::NUM_AXES],
	output logic                             adv,
	ibc_out_if.source                        results
);
	import ibc_pkg::*;

	logic                    vld_q;
	logic                    cal_q;
	logic signed [OUT_W-1:0] data_q [NUM_AXES];

	assign adv = !vld_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (adv) vld_q <= res_vld;
	end

	always_ff @(posedge clk) begin
		if (adv && res_vld) begin
			data_q <= corr;
			cal_q  <= cal;
		end
	end

	assign results.valid         = vld_q;
	assign results.acc_x_out     = data_q[0];
	assign results.acc_y_out     = data_q[1];
	assign results.acc_z_out     = data_q[2];
	assign results.gyro_x_out    = data_q[3];
	assign results.gyro_y_out    = data_q[4];
	assign results.gyro_z_out    = data_q[5];
	assign results.is_calibrated = cal_q;

endmodule

// File: hdl/imu_bias_calibrator.sv
// Six-axis IMU bias calibrator: top level.
// Requests arrive on "samples" (valid/ready): req_type 0 is an ordinary
// sample, 1 starts a bias capture, 2 clears the calibration, 3 is ignored.
// The next CAPTURE_LEN samples after a capture request are summed per axis
// and return nothing; after the last one each axis offset becomes the mean
// in 1/16 LSB, rounded half away from zero, and is_calibrated goes high.
// Every other ordinary sample returns one item on "results":
// raw*16 - offset for each axis, plus the calibrated flag.
// Throughput: one request per cycle while results does not stall. A result
// passes five lane stages, then the output register; these stages hold
// the reciprocal multiply and correction path of the mean.
// Six identical lanes run in parallel, one per axis.
// Reset (arst_n low, async) clears sums, offsets, capture state and flag;
// no result is pending afterward.
// When results stalls with a result held, the whole pipe holds and
// samples.ready drops until the result is taken.
module imu_bias_calibrator (
	input  logic      clk,
	input  logic      arst_n,
	ibc_in_if.sink    samples,
	ibc_out_if.source results
);
	import ibc_pkg::*;

	ibc_lane_ctl_t           ctl;
	logic                    adv;
	logic                    accept;
	logic                    res_vld;
	logic                    cal;
	logic signed [RAW_W-1:0] raw  [NUM_AXES];
	logic signed [OUT_W-1:0] corr [NUM_AXES];

	assign samples.ready = adv;
	assign accept        = samples.valid && adv;

	assign raw[0] = samples.acc_x_raw;
	assign raw[1] = samples.acc_y_raw;
	assign raw[2] = samples.acc_z_raw;
	assign raw[3] = samples.gyro_x_raw;
	assign raw[4] = samples.gyro_y_raw;
	assign raw[5] = samples.gyro_z_raw;

	ibc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.adv     (adv),
		.req     (samples.req_type),
		.ctl     (ctl),
		.res_vld (res_vld),
		.cal     (cal)
	);

	for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
		ibc_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.raw    (raw[i]),
			.corr   (corr[i])
		);
	end

	ibc_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.res_vld (res_vld),
		.cal     (cal),
		.corr    (corr),
		.adv     (adv),
		.results (results)
	);

endmodule
